// File: rtl/core/nscm_pkg.sv
`default_nettype none
package nscm_pkg;

  // Fixed field widths
  localparam int PT_W   = 24;
  localparam int CRD_W  = 16;
  localparam int SCL_W  = 16;
  localparam int SLOT_W = 3;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 4;
  localparam int CNT_W  = 5;

  localparam logic signed [PT_W-1:0] PT_MAX = 24'sh7FFFFF;
  localparam logic signed [PT_W-1:0] PT_MIN = -24'sh800000;

  typedef enum logic [OP_W-1:0] {
    OP_WR_LOGICAL = 2'd0,
    OP_WR_NATIVE  = 2'd1,
    OP_MAP_FWD    = 2'd2,
    OP_MAP_REV    = 2'd3
  } op_t;

  // Command handed from the front to the back through the queue
  typedef struct packed {
    op_t                      op;
    logic                     slot_ok;
    logic [SLOT_W-1:0]        slot;
    logic [CNT_W-1:0]         count;
    logic signed [CRD_W-1:0]  left;
    logic signed [CRD_W-1:0]  top;
    logic [CRD_W-1:0]         width;
    logic [CRD_W-1:0]         height;
    logic [SCL_W-1:0]         scale;
    logic signed [PT_W-1:0]   px;
    logic signed [PT_W-1:0]   py;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/nscm_if.sv
`default_nettype none
interface nscm_in_if;
  import nscm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [SLOT_W-1:0]        slot;
  logic signed [CRD_W-1:0]  rect_left;
  logic signed [CRD_W-1:0]  rect_top;
  logic [CRD_W-1:0]         rect_width;
  logic [CRD_W-1:0]         rect_height;
  logic [SCL_W-1:0]         pixel_scale;
  logic signed [PT_W-1:0]   point_x;
  logic signed [PT_W-1:0]   point_y;

  modport source (output valid, op, slot, rect_left, rect_top, rect_width, rect_height,
                  pixel_scale, point_x, point_y, input ready);
  modport sink (input valid, op, slot, rect_left, rect_top, rect_width, rect_height,
                pixel_scale, point_x, point_y, output ready);
endinterface

interface nscm_out_if;
  import nscm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PT_W-1:0]   out_x;
  logic signed [PT_W-1:0]   out_y;
  logic [SLOT_W-1:0]        screen_index;
  logic                     screen_found;
  logic                     saturated;

  modport source (output valid, out_x, out_y, screen_index, screen_found, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, screen_index, screen_found, saturated,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/nearest_screen_coordinate_mapper.sv
`default_nettype none
// Nearest-screen point mapper. Write items load a table of screens; a map item returns one
// result, a write item none. The front takes one item per cycle into a two-entry command
// queue while the back works and the queue has room. In the back a write is taken in the idle
// state; a map scans the screens in use, each through the gap, square, sum and compare states,
// then maps both axes: logical to native multiplies by the scale, native to logical runs the
// restoring divider one quotient bit per cycle over an NW-bit numerator (NW = 40 with the
// default widths), each axis ending in a clamp step before the result goes out.
module nearest_screen_coordinate_mapper
  import nscm_pkg::*;
#(
  parameter int NUM_SCREENS     = 8,
  parameter int POINT_FRAC_BITS = 8,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  nscm_in_if.sink               in_ch,
  nscm_out_if.source            out_ch
);

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  nscm_front #(
    .NUM_SCREENS (NUM_SCREENS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  nscm_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  nscm_back #(
    .NUM_SCREENS     (NUM_SCREENS),
    .POINT_FRAC_BITS (POINT_FRAC_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: rtl/core/nscm_front.sv
`default_nettype none
module nscm_front
  import nscm_pkg::*;
#(
  parameter int NUM_SCREENS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  nscm_in_if.sink               in_ch,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output cmd_t                  push_data
);

  logic [CFG_W-1:0] screen_count;
  logic [CNT_W-1:0] count_eff;

  // Screen count register
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_count <= '0;
    end else if (cfg_wr_en) begin
      screen_count <= cfg_wr_data;
    end
  end

  // Clip count to the table size
  always_comb begin
    if (CNT_W'(screen_count) > CNT_W'(NUM_SCREENS)) begin
      count_eff = CNT_W'(NUM_SCREENS);
    end else begin
      count_eff = CNT_W'(screen_count);
    end
  end

  // Classify and pass on
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_data         = '0;
    push_data.op      = op_t'(in_ch.op);
    push_data.slot    = in_ch.slot;
    push_data.slot_ok = (CNT_W'(in_ch.slot) < CNT_W'(NUM_SCREENS));
    push_data.count   = count_eff;
    push_data.left    = in_ch.rect_left;
    push_data.top     = in_ch.rect_top;
    push_data.width   = in_ch.rect_width;
    push_data.height  = in_ch.rect_height;
    push_data.scale   = in_ch.pixel_scale;
    push_data.px      = in_ch.point_x;
    push_data.py      = in_ch.point_y;
  end

endmodule
`default_nettype wire

// File: rtl/core/nscm_cmd_fifo.sv
`default_nettype none
module nscm_cmd_fifo
  import nscm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/nscm_back.sv
`default_nettype none
module nscm_back
  import nscm_pkg::*;
#(
  parameter int NUM_SCREENS     = 8,
  parameter int POINT_FRAC_BITS = 8,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  nscm_out_if.source out_ch
);

  localparam int IW   = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;
  localparam int PFB  = POINT_FRAC_BITS;
  localparam int SFB  = SCALE_FRAC_BITS;
  localparam int EW   = CRD_W + 2 + PFB;                          // edge in point units
  localparam int GW   = ((EW > PT_W) ? EW : PT_W) + 1;            // axis gap
  localparam int H    = (GW + 1) / 2;                             // low half of gap
  localparam int HH   = GW - H;                                   // high half of gap
  localparam int DSW  = 2 * GW + 1;                               // squared distance
  localparam int DW   = (((CRD_W + PFB) > PT_W) ? (CRD_W + PFB) : PT_W) + 1;
  localparam int MW   = DW + SCL_W + 2;                           // forward product
  localparam int NW   = DW + SFB + 3;                             // divider numerator
  localparam int DVW  = SCL_W + 1;                                // divisor 2*scale
  localparam int WW   = DW + SFB + 24;                            // result before clamp
  localparam int QCW  = $clog2(NW + 1);
  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (SFB - 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_GAP  = 10'b0000000010,
    ST_SQR  = 10'b0000000100,
    ST_SUM  = 10'b0000001000,
    ST_CMP  = 10'b0000010000,
    ST_PREP = 10'b0000100000,
    ST_AXIS = 10'b0001000000,
    ST_DIV  = 10'b0010000000,
    ST_FIN  = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_t;

  // Screen table
  logic signed [CRD_W-1:0] lg_left [NUM_SCREENS];
  logic signed [CRD_W-1:0] lg_top  [NUM_SCREENS];
  logic [CRD_W-1:0]        lg_w    [NUM_SCREENS];
  logic [CRD_W-1:0]        lg_h    [NUM_SCREENS];
  logic signed [CRD_W-1:0] nt_left [NUM_SCREENS];
  logic signed [CRD_W-1:0] nt_top  [NUM_SCREENS];
  logic [CRD_W-1:0]        nt_w    [NUM_SCREENS];
  logic [CRD_W-1:0]        nt_h    [NUM_SCREENS];
  logic [SCL_W-1:0]        scl     [NUM_SCREENS];

  state_t                  state;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        cnt;
  logic                    fwd;
  logic signed [PT_W-1:0]  px;
  logic signed [PT_W-1:0]  py;
  logic                    found;
  logic [IW-1:0]           best;
  logic [DSW-1:0]          best_d;
  logic [GW-1:0]           gx;
  logic [GW-1:0]           gy;
  logic [2*HH-1:0]         x_hh;
  logic [GW-1:0]           x_hl;
  logic [2*H-1:0]          x_ll;
  logic [2*HH-1:0]         y_hh;
  logic [GW-1:0]           y_hl;
  logic [2*H-1:0]          y_ll;
  logic [DSW-1:0]          sq_dist;
  logic signed [DW-1:0]    diff_x;
  logic signed [DW-1:0]    diff_y;
  logic signed [CRD_W-1:0] to_x;
  logic signed [CRD_W-1:0] to_y;
  logic [SCL_W-1:0]        scale_r;
  logic                    axis;
  logic signed [MW-1:0]    prod;
  logic [NW-1:0]           dm;
  logic [DVW-1:0]          rem;
  logic [DVW-1:0]          dvs;
  logic                    neg;
  logic [QCW-1:0]          dcnt;
  logic signed [PT_W-1:0]  res_x;
  logic signed [PT_W-1:0]  res_y;
  logic                    sat;

  logic                    out_valid;
  logic signed [PT_W-1:0]  out_x;
  logic signed [PT_W-1:0]  out_y;
  logic [SLOT_W-1:0]       out_idx;
  logic                    out_found;
  logic                    out_sat;

  logic [IW-1:0]           ix;
  logic signed [CRD_W-1:0] s_l;
  logic signed [CRD_W-1:0] s_t;
  logic [CRD_W-1:0]        s_w;
  logic [CRD_W-1:0]        s_h;
  logic [GW-1:0]           gap_x;
  logic [GW-1:0]           gap_y;
  logic signed [CRD_W-1:0] f_l;
  logic signed [CRD_W-1:0] f_t;
  logic signed [CRD_W-1:0] t_l;
  logic signed [CRD_W-1:0] t_t;
  logic signed [DW-1:0]    cur_diff;
  logic signed [CRD_W-1:0] cur_to;
  logic [SCL_W-1:0]        dd;
  logic signed [NW-1:0]    nn;
  logic [DVW:0]            rem_sh;
  logic                    ge;
  logic signed [WW-1:0]    qv;
  logic signed [WW-1:0]    val;
  logic [IW-1:0]           wslot;

  // Gap from a point to the span [lo, hi], zero when inside
  function automatic logic [GW-1:0] axis_gap(input logic signed [GW-1:0] p,
                                             input logic signed [GW-1:0] lo,
                                             input logic signed [GW-1:0] hi);
    logic [GW-1:0] g;
    if (lo > p) begin
      g = GW'(lo - p);
    end else if (p > hi) begin
      g = GW'(p - hi);
    end else begin
      g = '0;
    end
    return g;
  endfunction

  // Rectangle of the screen under scan, in the source space
  assign ix = idx[IW-1:0];

  always_comb begin
    if (fwd) begin
      s_l = lg_left[ix];
      s_t = lg_top[ix];
      s_w = lg_w[ix];
      s_h = lg_h[ix];
    end else begin
      s_l = nt_left[ix];
      s_t = nt_top[ix];
      s_w = nt_w[ix];
      s_h = nt_h[ix];
    end
  end

  always_comb begin
    logic signed [EW-1:0] le;
    logic signed [EW-1:0] re;
    logic signed [EW-1:0] te;
    logic signed [EW-1:0] be;
    le = EW'(s_l) <<< PFB;
    re = (EW'(s_l) + EW'($signed({1'b0, s_w}))) <<< PFB;
    te = EW'(s_t) <<< PFB;
    be = (EW'(s_t) + EW'($signed({1'b0, s_h}))) <<< PFB;
    gap_x = axis_gap(GW'(px), GW'(le), GW'(re));
    gap_y = axis_gap(GW'(py), GW'(te), GW'(be));
  end

  // Origins of the chosen screen
  always_comb begin
    if (fwd) begin
      f_l = lg_left[best];
      f_t = lg_top[best];
      t_l = nt_left[best];
      t_t = nt_top[best];
    end else begin
      f_l = nt_left[best];
      f_t = nt_top[best];
      t_l = lg_left[best];
      t_t = lg_top[best];
    end
  end

  // Per-axis operands, divider step and final value
  assign cur_diff = axis ? diff_y : diff_x;
  assign cur_to   = axis ? to_y : to_x;
  assign dd       = (scale_r == '0) ? SCL_W'(1) : scale_r;
  assign nn       = (NW'(cur_diff) <<< (SFB + 1)) + NW'($signed({1'b0, dd}));
  assign rem_sh   = {rem, dm[NW-1]};
  assign ge       = (rem_sh >= {1'b0, dvs});

  always_comb begin
    logic signed [NW:0] qs;
    qs = $signed({1'b0, dm});
    if (neg) begin
      qv = -WW'(qs);
    end else begin
      qv = WW'(qs);
    end
  end

  always_comb begin
    logic signed [MW-1:0] rnd;
    rnd = (prod + HALF) >>> SFB;
    if (fwd) begin
      val = (WW'(cur_to) <<< PFB) + WW'(rnd);
    end else begin
      val = (WW'(cur_to) <<< PFB) + qv;
    end
  end

  assign wslot     = IW'(cmd.slot);
  assign cmd_ready = (state == ST_IDLE);

  // Table writes
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd.slot_ok) begin
      if (cmd.op == OP_WR_LOGICAL) begin
        lg_left[wslot] <= cmd.left;
        lg_top[wslot]  <= cmd.top;
        lg_w[wslot]    <= cmd.width;
        lg_h[wslot]    <= cmd.height;
      end else if (cmd.op == OP_WR_NATIVE) begin
        nt_left[wslot] <= cmd.left;
        nt_top[wslot]  <= cmd.top;
        nt_w[wslot]    <= cmd.width;
        nt_h[wslot]    <= cmd.height;
        scl[wslot]     <= cmd.scale;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // ST_OUT reloads the result register itself on a transfer
      if (out_valid && out_ch.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && (cmd.op == OP_MAP_FWD || cmd.op == OP_MAP_REV)) begin
            fwd   <= (cmd.op == OP_MAP_FWD);
            px    <= cmd.px;
            py    <= cmd.py;
            cnt   <= cmd.count;
            idx   <= '0;
            found <= 1'b0;
            best  <= '0;
            sat   <= 1'b0;
            res_x <= cmd.px;
            res_y <= cmd.py;
            if (cmd.count == '0) begin
              state <= ST_OUT;
            end else begin
              state <= ST_GAP;
            end
          end
        end
        ST_GAP: begin
          gx    <= gap_x;
          gy    <= gap_y;
          state <= ST_SQR;
        end
        ST_SQR: begin
          x_hh  <= gx[GW-1:H] * gx[GW-1:H];
          x_hl  <= gx[GW-1:H] * gx[H-1:0];
          x_ll  <= gx[H-1:0] * gx[H-1:0];
          y_hh  <= gy[GW-1:H] * gy[GW-1:H];
          y_hl  <= gy[GW-1:H] * gy[H-1:0];
          y_ll  <= gy[H-1:0] * gy[H-1:0];
          state <= ST_SUM;
        end
        ST_SUM: begin
          sq_dist <= (DSW'(x_hh) << (2 * H)) + (DSW'(x_hl) << (H + 1)) + DSW'(x_ll)
                   + (DSW'(y_hh) << (2 * H)) + (DSW'(y_hl) << (H + 1)) + DSW'(y_ll);
          state   <= ST_CMP;
        end
        ST_CMP: begin
          // Strict less keeps the lowest slot on a tie
          if (!found || sq_dist < best_d) begin
            found  <= 1'b1;
            best   <= ix;
            best_d <= sq_dist;
          end
          idx <= idx + CNT_W'(1);
          if (idx + CNT_W'(1) == cnt) begin
            state <= ST_PREP;
          end else begin
            state <= ST_GAP;
          end
        end
        ST_PREP: begin
          diff_x  <= DW'(px) - (DW'(f_l) <<< PFB);
          diff_y  <= DW'(py) - (DW'(f_t) <<< PFB);
          to_x    <= t_l;
          to_y    <= t_t;
          scale_r <= scl[best];
          axis    <= 1'b0;
          state   <= ST_AXIS;
        end
        ST_AXIS: begin
          if (fwd) begin
            prod  <= cur_diff * $signed({1'b0, scale_r});
            state <= ST_FIN;
          end else begin
            // Floor division: negative numerators divide |N| + D - 1
            neg  <= nn[NW-1];
            dvs  <= {dd, 1'b0};
            rem  <= '0;
            dcnt <= '0;
            if (nn[NW-1]) begin
              dm <= NW'(-nn) + NW'({dd, 1'b0}) - NW'(1);
            end else begin
              dm <= NW'(nn);
            end
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= ge ? DVW'(rem_sh - {1'b0, dvs}) : DVW'(rem_sh);
          dm   <= {dm[NW-2:0], ge};
          dcnt <= dcnt + QCW'(1);
          if (dcnt == QCW'(NW - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          logic signed [PT_W-1:0] cl;
          logic                   cs;
          cs = 1'b0;
          if (val > WW'(PT_MAX)) begin
            cl = PT_MAX;
            cs = 1'b1;
          end else if (val < WW'(PT_MIN)) begin
            cl = PT_MIN;
            cs = 1'b1;
          end else begin
            cl = PT_W'(val);
          end
          if (cs) begin
            sat <= 1'b1;
          end
          if (axis) begin
            res_y <= cl;
            state <= ST_OUT;
          end else begin
            res_x <= cl;
            axis  <= 1'b1;
            state <= ST_AXIS;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_x     <= res_x;
            out_y     <= res_y;
            out_idx   <= found ? SLOT_W'(best) : '0;
            out_found <= found;
            out_sat   <= sat;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  assign out_ch.valid        = out_valid;
  assign out_ch.out_x        = out_x;
  assign out_ch.out_y        = out_y;
  assign out_ch.screen_index = out_idx;
  assign out_ch.screen_found = out_found;
  assign out_ch.saturated    = out_sat;

endmodule
`default_nettype wire

// File: tb/sv/nearest_screen_coordinate_mapper_test.sv
`default_nettype none
module nearest_screen_coordinate_mapper_test;
  import nscm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREENS    = 8;
  localparam int SETTLE     = 250;   // longer than the slowest reverse map
  localparam int STALL_MAX  = 5000;
  localparam int PHASE_LEN  = 165;

  typedef struct {
    op_t                     op;
    logic [SLOT_W-1:0]       slot;
    logic signed [CRD_W-1:0] left;
    logic signed [CRD_W-1:0] top;
    logic [CRD_W-1:0]        width;
    logic [CRD_W-1:0]        height;
    logic [SCL_W-1:0]        scale;
    logic signed [PT_W-1:0]  px;
    logic signed [PT_W-1:0]  py;
  } req_t;

  typedef struct {
    logic signed [PT_W-1:0]  x;
    logic signed [PT_W-1:0]  y;
    logic [SLOT_W-1:0]       idx;
    logic                    found;
    logic                    sat;
  } point_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  nscm_in_if  in_ch();
  nscm_out_if out_ch();

  nearest_screen_coordinate_mapper dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the screen table and count register
  logic signed [CRD_W-1:0] lg_left [SCREENS];
  logic signed [CRD_W-1:0] lg_top  [SCREENS];
  logic [CRD_W-1:0]        lg_w    [SCREENS];
  logic [CRD_W-1:0]        lg_h    [SCREENS];
  logic signed [CRD_W-1:0] nt_left [SCREENS];
  logic signed [CRD_W-1:0] nt_top  [SCREENS];
  logic [CRD_W-1:0]        nt_w    [SCREENS];
  logic [CRD_W-1:0]        nt_h    [SCREENS];
  logic [SCL_W-1:0]        scl     [SCREENS];
  logic [CFG_W-1:0]        screens_in_use = '0;

  req_t       pending_reqs[$];
  point_res_t expected_points[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         mismatches = 0;
  int         maps_seen = 0;
  int         reqs_taken = 0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint axis_gap(longint p, longint lo, longint hi);
    if (lo > p) return lo - p;
    if (p > hi) return p - hi;
    return 0;
  endfunction

  function automatic longint map_axis(longint p, longint from_org, longint to_org,
                                      longint sc, bit fwd, inout bit sat);
    longint diff, q, d, v;
    diff = p - from_org * 256;
    if (fwd) begin
      q = fdiv(diff * sc + 2048, 4096);
    end else begin
      d = (sc == 0) ? 1 : sc;
      q = fdiv(2 * diff * 4096 + d, 2 * d);
    end
    v = to_org * 256 + q;
    if (v > 8388607) begin
      sat = 1'b1;
      v = 8388607;
    end else if (v < -8388608) begin
      sat = 1'b1;
      v = -8388608;
    end
    return v;
  endfunction

  // Update the shadow table or work out the mapped point; returns 1 when a result follows.
  function automatic bit predict_mapping(req_t r, output point_res_t res);
    int n, best;
    bit fwd, found, sat;
    longint l, t, rr, b, sq_dist, best_dist, px, py;
    px = longint'(r.px);
    py = longint'(r.py);
    res = '{x: r.px, y: r.py, idx: '0, found: 1'b0, sat: 1'b0};
    if (r.op == OP_WR_LOGICAL) begin
      lg_left[r.slot] = r.left; lg_top[r.slot] = r.top;
      lg_w[r.slot] = r.width;   lg_h[r.slot] = r.height;
      return 1'b0;
    end
    if (r.op == OP_WR_NATIVE) begin
      nt_left[r.slot] = r.left; nt_top[r.slot] = r.top;
      nt_w[r.slot] = r.width;   nt_h[r.slot] = r.height;
      scl[r.slot] = r.scale;
      return 1'b0;
    end
    fwd = (r.op == OP_MAP_FWD);
    n = (screens_in_use > SCREENS) ? SCREENS : screens_in_use;
    found = 1'b0;
    sat = 1'b0;
    best = 0;
    best_dist = 0;
    for (int i = 0; i < n; i++) begin
      l = fwd ? longint'(lg_left[i]) : longint'(nt_left[i]);
      t = fwd ? longint'(lg_top[i]) : longint'(nt_top[i]);
      rr = l + (fwd ? longint'(lg_w[i]) : longint'(nt_w[i]));
      b = t + (fwd ? longint'(lg_h[i]) : longint'(nt_h[i]));
      sq_dist = axis_gap(px, l * 256, rr * 256) ** 2 + axis_gap(py, t * 256, b * 256) ** 2;
      if (!found || sq_dist < best_dist) begin
        found = 1'b1;
        best = i;
        best_dist = sq_dist;
      end
    end
    if (found) begin
      px = map_axis(px, fwd ? lg_left[best] : nt_left[best],
                    fwd ? nt_left[best] : lg_left[best], scl[best], fwd, sat);
      py = map_axis(py, fwd ? lg_top[best] : nt_top[best],
                    fwd ? nt_top[best] : lg_top[best], scl[best], fwd, sat);
      res.x = px[PT_W-1:0];
      res.y = py[PT_W-1:0];
      res.idx = best[SLOT_W-1:0];
      res.found = 1'b1;
      res.sat = sat;
    end
    return 1'b1;
  endfunction

  // Driver: one transfer per handshake, valid held until taken
  req_t cur_req;
  always @(posedge clk) begin
    point_res_t pr;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reqs_taken++;
        if (predict_mapping(cur_req, pr)) expected_points.push_back(pr);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.op          <= cur_req.op;
        in_ch.slot        <= cur_req.slot;
        in_ch.rect_left   <= cur_req.left;
        in_ch.rect_top    <= cur_req.top;
        in_ch.rect_width  <= cur_req.width;
        in_ch.rect_height <= cur_req.height;
        in_ch.pixel_scale <= cur_req.scale;
        in_ch.point_x     <= cur_req.px;
        in_ch.point_y     <= cur_req.py;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", maps_seen, what, got, want);
    mismatches++;
  endtask

  // Monitor: checks each result transfer; one long hold-off to back the block up
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    point_res_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_points.size() == 0) begin
          report("unexpected result, x", out_ch.out_x, 0);
        end else begin
          e = expected_points.pop_front();
          if (out_ch.out_x !== e.x) report("out_x", out_ch.out_x, e.x);
          if (out_ch.out_y !== e.y) report("out_y", out_ch.out_y, e.y);
          if (out_ch.screen_index !== e.idx)
            report("screen_index", out_ch.screen_index, e.idx);
          if (out_ch.screen_found !== e.found)
            report("screen_found", out_ch.screen_found, e.found);
          if (out_ch.saturated !== e.sat) report("saturated", out_ch.saturated, e.sat);
        end
        maps_seen++;
      end
      if (!hold_done && maps_seen == 40) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("watchdog expired with %0d results outstanding", expected_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t wr_req(op_t op, int slot, int l, int t, int w, int h, int sc);
    req_t r;
    r = '{op: op, slot: slot[SLOT_W-1:0], left: l[CRD_W-1:0], top: t[CRD_W-1:0],
          width: w[CRD_W-1:0], height: h[CRD_W-1:0], scale: sc[SCL_W-1:0],
          px: PT_W'($urandom), py: PT_W'($urandom)};
    return r;
  endfunction

  function automatic req_t map_req(op_t op, int x, int y);
    req_t r;
    r = '{op: op, slot: SLOT_W'($urandom), left: CRD_W'($urandom), top: CRD_W'($urandom),
          width: CRD_W'($urandom), height: CRD_W'($urandom), scale: SCL_W'($urandom),
          px: x[PT_W-1:0], py: y[PT_W-1:0]};
    return r;
  endfunction

  // Random item: mostly screens of moderate size and points near them
  function automatic req_t random_req();
    int k, s, l, t, w, h, sc, x, y;
    bit fwd;
    k = $urandom_range(99);
    s = $urandom_range(SCREENS - 1);
    if (k < 25) begin
      if ($urandom_range(9) == 0) begin
        l = $urandom; t = $urandom; w = $urandom; h = $urandom;
      end else begin
        l = $urandom_range(8000) - 4000; t = $urandom_range(8000) - 4000;
        w = $urandom_range(3000); h = $urandom_range(3000);
      end
      case ($urandom_range(9))
        0: sc = 0;
        1: sc = 16'hFFFF;
        2: sc = $urandom;
        default: sc = $urandom_range(2048, 16384);
      endcase
      return wr_req(($urandom_range(1) == 0) ? OP_WR_LOGICAL : OP_WR_NATIVE, s, l, t, w, h, sc);
    end
    fwd = $urandom_range(1);
    if (k < 40) begin
      x = $urandom; y = $urandom;
    end else begin
      l = fwd ? lg_left[s] : nt_left[s];
      t = fwd ? lg_top[s] : nt_top[s];
      x = l * 256 + $urandom_range(800000) - 200000;
      y = t * 256 + $urandom_range(800000) - 200000;
    end
    return map_req(fwd ? OP_MAP_FWD : OP_MAP_REV, x, y);
  endfunction

  // Wait for all items taken and all results back, then for the block to settle
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_ch.valid || expected_points.size() > 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_screen_count(int n);
    drain();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[CFG_W-1:0];
    screens_in_use = n[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  int counts[8] = '{8, 3, 15, 1, 0, 5, 8, 6};
  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_WR_LOGICAL;
    in_ch.slot = '0;
    in_ch.rect_left = '0;
    in_ch.rect_top = '0;
    in_ch.rect_width = '0;
    in_ch.rect_height = '0;
    in_ch.pixel_scale = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < SCREENS; i++) begin
      lg_left[i] = '0; lg_top[i] = '0; lg_w[i] = '0; lg_h[i] = '0;
      nt_left[i] = '0; nt_top[i] = '0; nt_w[i] = '0; nt_h[i] = '0; scl[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: passthrough with no screens, table load with extremes, edge maps
    send_idle_pct <= 10;
    recv_idle_pct <= 79;
    pending_reqs.push_back(map_req(OP_MAP_FWD, 8388607, -8388608));
    pending_reqs.push_back(map_req(OP_MAP_REV, -8388608, 8388607));
    pending_reqs.push_back(wr_req(OP_WR_LOGICAL, 0, -32768, -32768, 65535, 65535, 0));
    pending_reqs.push_back(wr_req(OP_WR_NATIVE, 0, 32767, 32767, 0, 0, 16'hFFFF));
    pending_reqs.push_back(wr_req(OP_WR_LOGICAL, 1, 32767, 32767, 0, 0, 0));
    pending_reqs.push_back(wr_req(OP_WR_NATIVE, 1, -32768, -32768, 65535, 65535, 0));
    for (int i = 2; i < SCREENS; i++) begin
      // slots 2 and 3 share a rectangle so a tie picks the lower one
      pending_reqs.push_back(wr_req(OP_WR_LOGICAL, i, (i < 4) ? 100 : i * 500, 100, 200,
                                    150, 0));
      pending_reqs.push_back(wr_req(OP_WR_NATIVE, i, (i < 4) ? 200 : i * 700, 200, 300,
                                    220, 4096 + i * 1000));
    end
    set_screen_count(8);
    pending_reqs.push_back(map_req(OP_MAP_FWD, 8388607, 8388607));
    pending_reqs.push_back(map_req(OP_MAP_FWD, -8388608, -8388608));
    pending_reqs.push_back(map_req(OP_MAP_REV, 8388607, 8388607));
    pending_reqs.push_back(map_req(OP_MAP_REV, -8388608, -8388608));
    pending_reqs.push_back(map_req(OP_MAP_FWD, 150 * 256 + 17, 160 * 256 + 129));
    pending_reqs.push_back(map_req(OP_MAP_REV, 250 * 256 + 3, 210 * 256 - 5));

    // random phases over several screen counts and idle profiles
    for (int p = 0; p < 8; p++) begin
      set_screen_count(counts[p]);
      send_idle_pct <= (p < 3) ? 10 : (p < 6) ? 79 : 0;
      recv_idle_pct <= (p < 3) ? 79 : (p < 6) ? 10 : 0;
      for (int i = 0; i < PHASE_LEN; i++) pending_reqs.push_back(random_req());
    end
    drain();
    $display("%0d items taken, %0d mapped points checked across screen counts 0 to 15",
             reqs_taken, maps_seen);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
